>>> rtl/kslc_pkg.sv
package kslc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BIT_PHASE  = 2'd0;
  localparam logic [1:0] REG_HS_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_BUS_FREE   = 2'd2;
  localparam logic [1:0] REG_RESET_HOLD = 2'd3;

  localparam int unsigned CFG_ADDR_W = 4;

  // Register reset values
  localparam logic [9:0]  BIT_PHASE_RST  = 10'd20;
  localparam logic [19:0] HS_TIMEOUT_RST = 20'd143000;
  localparam logic [9:0]  BUS_FREE_RST   = 10'd100;
  localparam logic [19:0] RESET_HOLD_RST = 20'd500000;

  typedef struct packed {
    logic [9:0]  bit_phase;
    logic [19:0] hs_timeout;
    logic [9:0]  bus_free;
    logic [19:0] reset_hold;
  } cfg_t;

endpackage

>>> rtl/kslc_regs.sv
module kslc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kslc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output kslc_pkg::cfg_t                  cfg
);
  import kslc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write a register on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_phase  <= BIT_PHASE_RST;
      cfg.hs_timeout <= HS_TIMEOUT_RST;
      cfg.bus_free   <= BUS_FREE_RST;
      cfg.reset_hold <= RESET_HOLD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BIT_PHASE:  cfg.bit_phase  <= pwdata[9:0];
        REG_HS_TIMEOUT: cfg.hs_timeout <= pwdata[19:0];
        REG_BUS_FREE:   cfg.bus_free   <= pwdata[9:0];
        REG_RESET_HOLD: cfg.reset_hold <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    case (reg_idx)
      REG_BIT_PHASE:  prdata = {22'd0, cfg.bit_phase};
      REG_HS_TIMEOUT: prdata = {12'd0, cfg.hs_timeout};
      REG_BUS_FREE:   prdata = {22'd0, cfg.bus_free};
      REG_RESET_HOLD: prdata = {12'd0, cfg.reset_hold};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/keyboard_serial_link_controller.sv
// Latency: a result is valid in the cycle after its input transaction is accepted.
// Throughput: one item per cycle while the result stream is not stalled; the next-state logic is a single pass per item
// and the output register frees as soon as its result is taken.
// Reset (rst, synchronous): link lost sync, sequencer idle, counters, shift bits
// and modifiers cleared, configuration registers at their defaults.
module keyboard_serial_link_controller (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kslc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // key_code[7:0], clk_line[8],
                                                         // data_line[9], zero[15:10]
  input  logic                            s_axis_tuser,  // action[0]
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata   // clk_sink[0], data_sink[1],
                                                         // link_mode[3:2], busy_res[4],
                                                         // status[7:5]
);
  import kslc_pkg::*;

  localparam logic [1:0] LINK_LOST  = 2'd0;
  localparam logic [1:0] LINK_SYNC  = 2'd1;
  localparam logic [1:0] LINK_RESET = 2'd2;

  localparam logic [2:0] ST_NONE         = 3'd0;
  localparam logic [2:0] ST_KEY_SENT     = 3'd1;
  localparam logic [2:0] ST_KEY_DROPPED  = 3'd2;
  localparam logic [2:0] ST_TIMEOUT_LOST = 3'd3;
  localparam logic [2:0] ST_RESYNCED     = 3'd4;
  localparam logic [2:0] ST_RESET_START  = 3'd5;
  localparam logic [2:0] ST_RESET_END    = 3'd6;
  localparam logic [2:0] ST_KEY_REJECTED = 3'd7;

  localparam logic [7:0]  REBOOT_MASK = 8'hC8;
  localparam logic [19:0] COUNT_MAX   = 20'hFFFFF;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_BUSWAIT   = 6'b000010,
    PH_SETUP     = 6'b000100,
    PH_CLKLOW    = 6'b001000,
    PH_CLKHIGH   = 6'b010000,
    PH_HANDSHAKE = 6'b100000
  } phase_t;

  cfg_t cfg;

  kslc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [1:0]  link_state, link_next;
  phase_t      phase, phase_next;
  logic [7:0]  shift_bits, shift_next;
  logic [3:0]  bits_left, left_next;
  logic [19:0] tick_count, count_next;
  logic [7:0]  modifier_bits, mod_next;
  logic [2:0]  st_next;

  logic        accept;
  logic        action;
  logic [7:0]  key;
  logic        clk_in;
  logic        dat_in;
  logic [19:0] count_inc;
  logic [7:0]  mod_bit;
  logic [3:0]  left_dec;
  logic        sending;
  logic [7:0]  result;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign action        = s_axis_tuser;
  assign key           = s_axis_tdata[7:0];
  assign clk_in        = s_axis_tdata[8];
  assign dat_in        = s_axis_tdata[9];

  assign count_inc = (tick_count == COUNT_MAX) ? tick_count : tick_count + 20'd1;
  assign mod_bit   = 8'd1 << key[2:0];
  assign left_dec  = (bits_left != 4'd0) ? bits_left - 4'd1 : 4'd0;

  // Work out the next state and status for one item
  always_comb begin
    link_next  = link_state;
    phase_next = phase;
    shift_next = shift_bits;
    left_next  = bits_left;
    count_next = tick_count;
    mod_next   = modifier_bits;
    st_next    = ST_NONE;
    if (action) begin
      if (phase != PH_IDLE) begin
        st_next = ST_KEY_REJECTED;
      end else begin
        if (key[6:3] == 4'b1100) begin
          if (key[7]) mod_next = modifier_bits & ~mod_bit;
          else        mod_next = modifier_bits | mod_bit;
        end
        if ((mod_next & REBOOT_MASK) == REBOOT_MASK) begin
          link_next  = LINK_RESET;
          phase_next = PH_IDLE;
          count_next = 20'd0;
          st_next    = ST_RESET_START;
        end else if (link_state == LINK_SYNC && key != 8'hFF) begin
          shift_next = {key[6:0], key[7]};
          left_next  = 4'd8;
          phase_next = PH_BUSWAIT;
          count_next = 20'd0;
        end
      end
    end else if (link_state == LINK_RESET) begin
      // Hold the clock low until the hold time has passed and keys are released
      count_next = count_inc;
      if (count_inc >= cfg.reset_hold &&
          (modifier_bits & REBOOT_MASK) != REBOOT_MASK) begin
        link_next  = LINK_LOST;
        phase_next = PH_IDLE;
        count_next = 20'd0;
        st_next    = ST_RESET_END;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (link_state == LINK_LOST) begin
            shift_next = 8'h80;
            left_next  = 4'd1;
            phase_next = PH_BUSWAIT;
            count_next = 20'd0;
          end
        end
        PH_BUSWAIT: begin
          if (clk_in && dat_in) begin
            phase_next = PH_SETUP;
            count_next = 20'd0;
          end else begin
            count_next = count_inc;
            if (count_inc >= {10'd0, cfg.bus_free}) begin
              phase_next = PH_IDLE;
              count_next = 20'd0;
              left_next  = 4'd0;
              if (link_state == LINK_SYNC) st_next = ST_KEY_DROPPED;
            end
          end
        end
        PH_SETUP: begin
          count_next = count_inc;
          if (count_inc >= {10'd0, cfg.bit_phase}) begin
            phase_next = PH_CLKLOW;
            count_next = 20'd0;
          end
        end
        PH_CLKLOW: begin
          count_next = count_inc;
          if (count_inc >= {10'd0, cfg.bit_phase}) begin
            phase_next = PH_CLKHIGH;
            count_next = 20'd0;
          end
        end
        PH_CLKHIGH: begin
          count_next = count_inc;
          if (count_inc >= {10'd0, cfg.bit_phase}) begin
            shift_next = {shift_bits[6:0], 1'b0};
            left_next  = left_dec;
            phase_next = (left_dec == 4'd0) ? PH_HANDSHAKE : PH_SETUP;
            count_next = 20'd0;
          end
        end
        PH_HANDSHAKE: begin
          if (!dat_in) begin
            phase_next = PH_IDLE;
            count_next = 20'd0;
            if (link_state == LINK_SYNC) begin
              st_next = ST_KEY_SENT;
            end else begin
              link_next = LINK_SYNC;
              st_next   = ST_RESYNCED;
            end
          end else begin
            count_next = count_inc;
            if (count_inc >= cfg.hs_timeout) begin
              phase_next = PH_IDLE;
              count_next = 20'd0;
              if (link_state == LINK_SYNC) begin
                link_next = LINK_LOST;
                st_next   = ST_TIMEOUT_LOST;
              end
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
          count_next = 20'd0;
        end
      endcase
    end
  end

  // Build the result from the state after the item
  assign sending = (phase_next == PH_SETUP) || (phase_next == PH_CLKLOW) ||
                   (phase_next == PH_CLKHIGH);
  assign result  = {st_next,
                    phase_next != PH_IDLE,
                    link_next,
                    sending && shift_next[7],
                    (link_next == LINK_RESET) || (phase_next == PH_CLKLOW)};

  // Advance the link state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      link_state    <= LINK_LOST;
      phase         <= PH_IDLE;
      shift_bits    <= 8'd0;
      bits_left     <= 4'd0;
      tick_count    <= 20'd0;
      modifier_bits <= 8'd0;
    end else if (accept) begin
      link_state    <= link_next;
      phase         <= phase_next;
      shift_bits    <= shift_next;
      bits_left     <= left_next;
      tick_count    <= count_next;
      modifier_bits <= mod_next;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) m_axis_tdata <= result;
  end

  // Reboot reset always parks the sequencer
  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    link_state == LINK_RESET |-> phase == PH_IDLE)
    else $error("sequencer active during reboot reset");

  // A bit is only clocked out while bits remain
  a_bits_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SETUP || phase == PH_CLKLOW || phase == PH_CLKHIGH) |->
      bits_left != 4'd0)
    else $error("bit phase with no bits left");

  // An empty output register must never stall the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // Key sent is reported only out of the handshake phase
  a_sent_hs: assert property (@(posedge clk) disable iff (rst)
    accept && st_next == ST_KEY_SENT |-> phase == PH_HANDSHAKE && link_state == LINK_SYNC)
    else $error("key sent reported outside handshake");

  // A reboot reset result drives the clock low
  a_reset_clk: assert property (@(posedge clk) disable iff (rst)
    accept && link_next == LINK_RESET |=> m_axis_tdata[0])
    else $error("clock not held low in reboot reset");

endmodule
